// ===== hdl/cbt_pkg.sv =====
// ----------------------------------------------------------------------------
// cbt_pkg
// Types and constants shared by the filtered checkerboard texture block.
// ----------------------------------------------------------------------------
package cbt_pkg;

  localparam int DIFF_W = 27;
  localparam int QUOT_W = 17;
  localparam logic [QUOT_W-1:0] WEIGHT_ONE  = 17'd65536;
  localparam logic [QUOT_W-1:0] WEIGHT_HALF = 17'd32768;

  typedef enum logic [2:0] {
    REG_COLOR_A_RED   = 3'd0,
    REG_COLOR_A_GREEN = 3'd1,
    REG_COLOR_A_BLUE  = 3'd2,
    REG_COLOR_B_RED   = 3'd3,
    REG_COLOR_B_GREEN = 3'd4,
    REG_COLOR_B_BLUE  = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] tex_s;
    logic signed [31:0] tex_t;
    logic signed [31:0] s_per_x;
    logic signed [31:0] s_per_y;
    logic signed [31:0] t_per_x;
    logic signed [31:0] t_per_y;
  } req_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
  } rsp_t;

  typedef struct packed {
    logic [15:0] a_red;
    logic [15:0] a_green;
    logic [15:0] a_blue;
    logic [15:0] b_red;
    logic [15:0] b_green;
    logic [15:0] b_blue;
  } colors_t;

  typedef struct packed {
    logic one_check;
    logic odd;
    logic wide;
    logic s_zero;
    logic s_bit;
    logic t_zero;
    logic t_bit;
  } flags_t;

  typedef struct packed {
    flags_t              flags;
    logic [DIFF_W-1:0]   diff_s;
    logic [DIFF_W-1:0]   den_s;
    logic [DIFF_W-1:0]   diff_t;
    logic [DIFF_W-1:0]   den_t;
  } class_t;

endpackage

// ===== hdl/cbt_queue.sv =====
// ----------------------------------------------------------------------------
// cbt_queue
// Four-entry queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module cbt_queue
  import cbt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  class_t entry_in,
  input  logic   pop,
  output class_t entry_out,
  output logic   full,
  output logic   nonempty
);

  class_t     slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full      = (count == 3'd4);
  assign nonempty  = (count != 3'd0);
  assign entry_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + {2'b0, push} - {2'b0, pop};
    end
  end

endmodule

// ===== hdl/cbt_front.sv =====
// ----------------------------------------------------------------------------
// cbt_front
// Doubles coordinates, forms half widths and classifies each sample.
// ----------------------------------------------------------------------------
module cbt_front
  import cbt_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16
)
(
  input  logic   clk,
  input  logic   rst,
  input  logic   req_valid,
  output logic   req_stall,
  input  req_t   req,
  input  logic   full,
  output logic   push,
  output class_t entry
);

  localparam int CW = 36;
  localparam logic signed [CW-1:0] ONE  = 36'sd1 <<< COORD_FRAC_BITS;
  localparam logic signed [CW-1:0] MASK = ONE - 36'sd1;

  function automatic logic [34:0] dbl_abs(input logic signed [31:0] v);
    logic signed [CW-1:0] d;
    d = {{3{v[31]}}, v, 1'b0};
    return d[CW-1] ? 35'(-d) : 35'(d);
  endfunction

  function automatic logic signed [CW-1:0] stripe(input logic signed [CW-1:0] x);
    logic signed [CW-1:0] hf;
    hf = (x >>> (COORD_FRAC_BITS + 1)) <<< COORD_FRAC_BITS;
    return hf + (x[COORD_FRAC_BITS] ? (x & MASK) : '0);
  endfunction

  logic                 f1_valid;
  logic                 f2_valid;
  logic signed [CW-1:0] s;
  logic signed [CW-1:0] t;
  logic [34:0]          hs;
  logic [34:0]          ht;
  logic                 take2;
  logic                 f1_en;
  logic [34:0]          ax;
  logic [34:0]          ay;
  logic [34:0]          bx;
  logic [34:0]          by;
  logic signed [CW-1:0] hs_w;
  logic signed [CW-1:0] ht_w;
  logic signed [CW-1:0] s_lo;
  logic signed [CW-1:0] s_hi;
  logic signed [CW-1:0] t_lo;
  logic signed [CW-1:0] t_hi;
  logic signed [CW-1:0] ds;
  logic signed [CW-1:0] dt;
  logic                 use_s;
  logic                 use_t;
  class_t               entry_next;

  assign take2     = !f2_valid || !full;
  assign f1_en     = !f1_valid || take2;
  assign req_stall = !f1_en;
  assign push      = f2_valid && !full;

  always_comb begin
    ax = dbl_abs(req.s_per_x);
    ay = dbl_abs(req.s_per_y);
    bx = dbl_abs(req.t_per_x);
    by = dbl_abs(req.t_per_y);
    hs_w = signed'({1'b0, hs});
    ht_w = signed'({1'b0, ht});
    s_lo = s - hs_w;
    s_hi = s + hs_w;
    t_lo = t - ht_w;
    t_hi = t + ht_w;
    ds = stripe(s_hi) - stripe(s_lo);
    dt = stripe(t_hi) - stripe(t_lo);
    use_s = (hs != '0) && (hs_w <= ONE);
    use_t = (ht != '0) && (ht_w <= ONE);
    entry_next.flags.one_check =
        ((s_lo >>> COORD_FRAC_BITS) == (s_hi >>> COORD_FRAC_BITS)) &&
        ((t_lo >>> COORD_FRAC_BITS) == (t_hi >>> COORD_FRAC_BITS));
    entry_next.flags.odd    = s[COORD_FRAC_BITS] ^ t[COORD_FRAC_BITS];
    entry_next.flags.wide   = (hs_w > ONE) || (ht_w > ONE);
    entry_next.flags.s_zero = (hs == '0);
    entry_next.flags.s_bit  = s[COORD_FRAC_BITS];
    entry_next.flags.t_zero = (ht == '0);
    entry_next.flags.t_bit  = t[COORD_FRAC_BITS];
    entry_next.diff_s = (use_s && !ds[CW-1]) ? DIFF_W'(ds) : '0;
    entry_next.den_s  = use_s ? DIFF_W'({hs, 1'b0}) : DIFF_W'(1);
    entry_next.diff_t = (use_t && !dt[CW-1]) ? DIFF_W'(dt) : '0;
    entry_next.den_t  = use_t ? DIFF_W'({ht, 1'b0}) : DIFF_W'(1);
  end

  always_ff @(posedge clk) begin
    if (f1_en) begin
      s  <= {{3{req.tex_s[31]}}, req.tex_s, 1'b0};
      t  <= {{3{req.tex_t[31]}}, req.tex_t, 1'b0};
      hs <= (ax > ay) ? ax : ay;
      ht <= (bx > by) ? bx : by;
    end
    if (take2) begin
      entry <= entry_next;
    end
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (f1_en) begin
        f1_valid <= req_valid;
      end
      if (take2) begin
        f2_valid <= f1_valid;
      end
    end
  end

endmodule

// ===== hdl/cbt_div.sv =====
// ----------------------------------------------------------------------------
// cbt_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cbt_div
  import cbt_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DIFF_W-1:0] num,
  input  logic [DIFF_W-1:0] den,
  output logic [QUOT_W-1:0] quot
);

  logic [DIFF_W-1:0] r_q [QUOT_W];
  logic [DIFF_W-1:0] d_q [QUOT_W];
  logic [QUOT_W-1:0] q_q [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic [DIFF_W:0]   trial;
    logic [DIFF_W-1:0] d_in;
    logic [QUOT_W-1:0] q_in;
    logic              qbit;
    logic [DIFF_W-1:0] r_next;

    if (k == 0) begin : g_first
      assign trial = {1'b0, num};
      assign d_in  = den;
      assign q_in  = '0;
    end else begin : g_rest
      assign trial = {r_q[k-1], 1'b0};
      assign d_in  = d_q[k-1];
      assign q_in  = q_q[k-1];
    end

    assign qbit   = (trial >= {1'b0, d_in});
    assign r_next = qbit ? DIFF_W'(trial - {1'b0, d_in}) : DIFF_W'(trial);

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k] <= r_next;
        d_q[k] <= d_in;
        q_q[k] <= {q_in[QUOT_W-2:0], qbit};
      end
    end
  end

  assign quot = q_q[QUOT_W-1];

endmodule

// ===== hdl/cbt_back.sv =====
// ----------------------------------------------------------------------------
// cbt_back
// Divides the stripe integrals, forms the B area and blends the colors.
// ----------------------------------------------------------------------------
module cbt_back
  import cbt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    nonempty,
  input  class_t  entry,
  output logic    pop,
  input  colors_t colors,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output rsp_t    rsp
);

  logic              en;
  logic              v_q [QUOT_W];
  flags_t            f_q [QUOT_W];
  logic [QUOT_W-1:0] qs;
  logic [QUOT_W-1:0] qt;
  logic [QUOT_W-1:0] ws;
  logic [QUOT_W-1:0] wt;
  logic [33:0]       prod;
  logic signed [19:0] sum;
  logic [QUOT_W-1:0] area_next;
  logic              v_a;
  logic [QUOT_W-1:0] area;
  logic [QUOT_W-1:0] inv;
  logic              v_p;
  logic [32:0]       pa_r;
  logic [32:0]       pb_r;
  logic [32:0]       pa_g;
  logic [32:0]       pb_g;
  logic [32:0]       pa_b;
  logic [32:0]       pb_b;
  logic [33:0]       sr;
  logic [33:0]       sg;
  logic [33:0]       sb;

  assign en  = !rsp_valid || !rsp_stall;
  assign pop = en && nonempty;

  cbt_div u_div_s (
    .clk  (clk),
    .en   (en),
    .num  (entry.diff_s),
    .den  (entry.den_s),
    .quot (qs)
  );

  cbt_div u_div_t (
    .clk  (clk),
    .en   (en),
    .num  (entry.diff_t),
    .den  (entry.den_t),
    .quot (qt)
  );

  always_comb begin
    flags_t fl;
    fl = f_q[QUOT_W-1];
    ws = fl.s_zero ? (fl.s_bit ? WEIGHT_ONE : '0) : qs;
    wt = fl.t_zero ? (fl.t_bit ? WEIGHT_ONE : '0) : qt;
    prod = 34'(ws) * 34'(wt);
    sum = 20'(ws) + 20'(wt) - 20'(prod >> 15);
    if (fl.one_check) begin
      area_next = fl.odd ? WEIGHT_ONE : '0;
    end else if (fl.wide) begin
      area_next = WEIGHT_HALF;
    end else if (sum < 0) begin
      area_next = '0;
    end else if (sum > 20'sd65536) begin
      area_next = WEIGHT_ONE;
    end else begin
      area_next = QUOT_W'(sum);
    end
    inv = WEIGHT_ONE - area;
    sr = 34'(pa_r) + 34'(pb_r) + 34'd32768;
    sg = 34'(pa_g) + 34'(pb_g) + 34'd32768;
    sb = 34'(pa_b) + 34'(pb_b) + 34'd32768;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_q[0] <= entry.flags;
      for (int k = 1; k < QUOT_W; k++) begin
        f_q[k] <= f_q[k-1];
      end
      area <= area_next;
      pa_r <= 33'(colors.a_red) * 33'(inv);
      pb_r <= 33'(colors.b_red) * 33'(area);
      pa_g <= 33'(colors.a_green) * 33'(inv);
      pb_g <= 33'(colors.b_green) * 33'(area);
      pa_b <= 33'(colors.a_blue) * 33'(inv);
      pb_b <= 33'(colors.b_blue) * 33'(area);
      rsp.out_red   <= sr[31:16];
      rsp.out_green <= sg[31:16];
      rsp.out_blue  <= sb[31:16];
    end
    if (rst) begin
      for (int k = 0; k < QUOT_W; k++) begin
        v_q[k] <= 1'b0;
      end
      v_a       <= 1'b0;
      v_p       <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      v_q[0] <= nonempty;
      for (int k = 1; k < QUOT_W; k++) begin
        v_q[k] <= v_q[k-1];
      end
      v_a       <= v_q[QUOT_W-1];
      v_p       <= v_a;
      rsp_valid <= v_p;
    end
  end

endmodule

// ===== hdl/filtered_checkerboard_texture_top.sv =====
// ----------------------------------------------------------------------------
// filtered_checkerboard_texture_top
// Box-filtered checkerboard texture with six color registers.
// ----------------------------------------------------------------------------
// The block takes one sample per cycle while req_stall is low and returns one
// color per sample, in order. A sample passes the classifying front stages
// (coordinate and half width registers, then the entry register), the
// four-entry queue and the back pipeline: the seventeen-stage quotient divider,
// then the area, product and output registers. Color registers are written
// through the configuration port, which never stalls; the user must write them
// only while the block is idle, since the block itself does not enforce this.
module filtered_checkerboard_texture_top
  import cbt_pkg::*;
#(
  parameter int COORD_FRAC_BITS = 16
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  colors_t colors;
  class_t  entry_in;
  class_t  entry_out;
  logic    push;
  logic    pop;
  logic    full;
  logic    nonempty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      colors.a_red   <= 16'd0;
      colors.a_green <= 16'd0;
      colors.a_blue  <= 16'd0;
      colors.b_red   <= 16'd4096;
      colors.b_green <= 16'd4096;
      colors.b_blue  <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLOR_A_RED:   colors.a_red   <= cfg_data;
        REG_COLOR_A_GREEN: colors.a_green <= cfg_data;
        REG_COLOR_A_BLUE:  colors.a_blue  <= cfg_data;
        REG_COLOR_B_RED:   colors.b_red   <= cfg_data;
        REG_COLOR_B_GREEN: colors.b_green <= cfg_data;
        REG_COLOR_B_BLUE:  colors.b_blue  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cbt_front #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .full      (full),
    .push      (push),
    .entry     (entry_in)
  );

  cbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .entry_in  (entry_in),
    .pop       (pop),
    .entry_out (entry_out),
    .full      (full),
    .nonempty  (nonempty)
  );

  cbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .entry     (entry_out),
    .pop       (pop),
    .colors    (colors),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== tb/filtered_checkerboard_texture_top_tb.sv =====
// ----------------------------------------------------------------------------
// filtered_checkerboard_texture_top_tb
// Self-checking bench for the box-filtered checkerboard texture block. A table
// of directed samples is followed by random samples, mostly filter boxes of
// one check or less, with random gaps on both sides and several color settings
// written between phases. Every color beat is checked against a predictor.
// ----------------------------------------------------------------------------
module filtered_checkerboard_texture_top_tb;
  import cbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int N_RANDOM = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  filtered_checkerboard_texture_top DUT (.*);

  always #6 clk = ~clk;

  logic [15:0] color_regs [6];
  rsp_t expected_colors [$];
  int errors = 0;
  int beats_checked = 0;
  int samples_sent = 0;
  int stall_left = 0;
  bit sending_done = 1'b0;

  typedef struct {
    req_t sample;
    bit   fixed;
    rsp_t color;
  } stim_row_t;
  stim_row_t stim_table [$];

  function automatic longint floor_sh(longint v, int sh);
    return v >>> sh;
  endfunction

  function automatic longint stripe_int(longint x);
    longint hf, rem, over;
    hf = floor_sh(x, FB + 1);
    rem = x - (hf <<< (FB + 1));
    over = rem - (longint'(1) <<< FB);
    if (over < 0) over = 0;
    return (hf <<< FB) + over;
  endfunction

  function automatic longint axis_cover(longint c, longint h);
    longint d;
    if (h == 0) return floor_sh(c, FB) & 1 ? 65536 : 0;
    d = stripe_int(c + h) - stripe_int(c - h);
    if (d < 0) d = 0;
    return (d * 65536) / (h * 2);
  endfunction

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [15:0] mix(logic [15:0] a, logic [15:0] b, longint w);
    longint r;
    r = (longint'(a) * (65536 - w) + longint'(b) * w + 32768) >>> 16;
    return r[15:0];
  endfunction

  function automatic rsp_t filtered_color(req_t q);
    longint s, t, hs, ht, ws, wt, area, one;
    rsp_t r;
    one = longint'(1) <<< FB;
    s = longint'(q.tex_s) * 2;
    t = longint'(q.tex_t) * 2;
    hs = abs_l(longint'(q.s_per_x) * 2);
    if (abs_l(longint'(q.s_per_y) * 2) > hs) hs = abs_l(longint'(q.s_per_y) * 2);
    ht = abs_l(longint'(q.t_per_x) * 2);
    if (abs_l(longint'(q.t_per_y) * 2) > ht) ht = abs_l(longint'(q.t_per_y) * 2);
    if (floor_sh(s - hs, FB) == floor_sh(s + hs, FB) &&
        floor_sh(t - ht, FB) == floor_sh(t + ht, FB)) begin
      area = ((floor_sh(s, FB) + floor_sh(t, FB)) & 1) ? 65536 : 0;
    end else if (hs > one || ht > one) begin
      area = 32768;
    end else begin
      ws = axis_cover(s, hs);
      wt = axis_cover(t, ht);
      area = ws + wt - ((ws * wt) >>> 15);
      if (area < 0) area = 0;
      if (area > 65536) area = 65536;
    end
    r.out_red = mix(color_regs[REG_COLOR_A_RED], color_regs[REG_COLOR_B_RED], area);
    r.out_green = mix(color_regs[REG_COLOR_A_GREEN], color_regs[REG_COLOR_B_GREEN], area);
    r.out_blue = mix(color_regs[REG_COLOR_A_BLUE], color_regs[REG_COLOR_B_BLUE], area);
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] rand_small(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic req_t random_sample();
    req_t q;
    int kind;
    kind = $urandom_range(0, 9);
    q.tex_s = $urandom();
    q.tex_t = $urandom();
    if (kind < 5) begin
      q.s_per_x = rand_small(32768);
      q.s_per_y = rand_small(32768);
      q.t_per_x = rand_small(32768);
      q.t_per_y = rand_small(32768);
    end else if (kind < 7) begin
      q.s_per_x = rand_small(2048);
      q.s_per_y = rand_small(2048);
      q.t_per_x = rand_small(2048);
      q.t_per_y = rand_small(2048);
    end else if (kind < 8) begin
      q.s_per_x = 0;
      q.s_per_y = 0;
      q.t_per_x = rand_small(32768);
      q.t_per_y = rand_small(32768);
    end else begin
      q.s_per_x = $urandom();
      q.s_per_y = $urandom();
      q.t_per_x = $urandom();
      q.t_per_y = $urandom();
    end
    return q;
  endfunction

  task automatic send_sample(req_t q);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= q;
    expected_colors.push_back(filtered_color(q));
    @(posedge clk);
    while (req_stall) @(posedge clk);
    samples_sent++;
  endtask

  task automatic write_color(reg_index_t idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    color_regs[idx] = val;
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic add_row(logic signed [31:0] s, t, sx, sy, tx, ty, bit fx, rsp_t c);
    stim_row_t r;
    r.sample = '{s, t, sx, sy, tx, ty};
    r.fixed = fx;
    r.color = c;
    stim_table.push_back(r);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (stall_left != 0) begin
        rsp_stall <= 1'b1;
        stall_left = stall_left - 1;
      end else if ($urandom_range(0, 99) < 3) begin
        rsp_stall <= 1'b1;
        stall_left = $urandom_range(10, 40);
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < 25) ? 1'b1 : 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_colors.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected color beat %h", rsp);
      end else begin
        want = expected_colors.pop_front();
        beats_checked++;
        if (rsp !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h %h %h, got %h %h %h", want.out_red,
                     want.out_green, want.out_blue, rsp.out_red, rsp.out_green,
                     rsp.out_blue);
        end
      end
    end
  end

  initial begin
    rsp_t dark, light;
    stim_row_t r;
    logic [15:0] phase_val;
    color_regs[0] = 0; color_regs[1] = 0; color_regs[2] = 0;
    color_regs[3] = 4096; color_regs[4] = 4096; color_regs[5] = 4096;
    dark = '0;
    light = '{16'd4096, 16'd4096, 16'd4096};
    add_row(0, 0, 0, 0, 0, 0, 1, dark);
    add_row(32768, 0, 0, 0, 0, 0, 1, light);
    add_row(32768, 32768, 0, 0, 0, 0, 1, dark);
    add_row(-1, 0, 0, 0, 0, 0, 1, light);
    add_row(-1, -1, 0, 0, 0, 0, 1, dark);
    add_row(32'sh7fffffff, 0, 0, 0, 0, 0, 1, light);
    add_row(32'sh80000000, 0, 0, 0, 0, 0, 1, dark);
    add_row(0, 0, 32'sh7fffffff, 0, 0, 0, 1, '{16'd2048, 16'd2048, 16'd2048});
    add_row(0, 0, 0, 32'sh80000000, 0, 0, 1, '{16'd2048, 16'd2048, 16'd2048});
    add_row(0, 0, 0, 0, 32'sh80000000, 32'sh7fffffff, 1, '{16'd2048, 16'd2048, 16'd2048});
    add_row(16384, 16384, 1000, 0, 1000, 0, 0, dark);
    add_row(16384, 0, 32768, -32768, 0, 0, 0, dark);
    add_row(16384, 100, 0, 0, 32768, 32768, 0, dark);
    add_row(100, 16384, 0, 0, 32769, 0, 0, dark);
    add_row(16384, 16384, 16000, 0, 0, -16000, 0, dark);
    add_row(-16384, 0, 0, 0, -8192, 8192, 0, dark);
    add_row(1, -1, 5, -7, 3, 0, 0, dark);
    add_row(32'sh7fff0000, 32'sh80000000, 16000, 16000, 16000, 16000, 0, dark);
    add_row(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
            32'hffffffff, 0, dark);
    add_row(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
            32'haaaaaaaa, 0, dark);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (stim_table[i]) begin
      r = stim_table[i];
      send_sample(r.sample);
      if (r.fixed) expected_colors[$] = r.color;
    end
    drain();
    for (int phase = 0; phase < 5; phase++) begin
      for (int k = 0; k < 6; k++) begin
        case (phase)
          0: phase_val = 16'hffff;
          1: phase_val = k < 3 ? 16'hffff : 16'h0000;
          2: phase_val = 16'h0000;
          default: phase_val = $urandom();
        endcase
        write_color(reg_index_t'(k), phase_val);
      end
      cfg_valid <= 1'b0;
      repeat (N_RANDOM / 5) send_sample(random_sample());
      drain();
    end
    cfg_valid <= 1'b1;
    cfg_index <= 3'd6;
    cfg_data <= 16'h1234;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= 3'd7;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    repeat (8) send_sample(random_sample());
    drain();
    $display("Sent %0d samples over five color settings; %0d color beats checked.",
             samples_sent, beats_checked);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout");
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cbt_pkg.sv
hdl/cbt_queue.sv
hdl/cbt_front.sv
hdl/cbt_div.sv
hdl/cbt_back.sv
hdl/filtered_checkerboard_texture_top.sv
tb/filtered_checkerboard_texture_top_tb.sv
